[rtl/core/mpct_pkg.sv]
// ----------------------------------------------------------------------------
// mpct_pkg
// Shared constants, types and helpers for the mouse packet cursor tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mpct_pkg;

    localparam int COORD_BITS  = 12;
    localparam int CFG_W       = 13;
    localparam int BYTE_W      = 8;
    localparam int DELTA_W     = BYTE_W + 1;
    localparam int SUM_W       = COORD_BITS + 2;
    localparam int EXT_W       = (CFG_W > COORD_BITS + 1) ? CFG_W : COORD_BITS + 1;
    localparam int CAP         = 1 << COORD_BITS;
    localparam int OUT_BITS    = 2 * COORD_BITS + 3;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // header byte bit positions
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_SYNC   = 3;
    localparam int HDR_XSIGN  = 4;
    localparam int HDR_YSIGN  = 5;

    // byte phase codes
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_XBYTE  = 2'd1;
    localparam logic [1:0] PH_YBYTE  = 2'd2;

    // config register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // completed packet, handed from assembler to cursor unit
    typedef struct packed {
        logic                      done;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic                      left;
        logic                      middle;
        logic                      right;
    } t_pkt;

    // clamp v to 0 .. res-1; res of zero pins to 0, res above CAP saturates
    function automatic logic [COORD_BITS-1:0] clamp_axis(
        input logic signed [SUM_W-1:0] v,
        input logic [CFG_W-1:0]        res
    );
        logic [EXT_W-1:0]        res_e;
        logic [COORD_BITS-1:0]   hi;
        logic signed [SUM_W-1:0] hi_s;
        logic [COORD_BITS-1:0]   r;
        res_e = EXT_W'(res);
        if (res_e == '0) begin
            hi = '0;
        end else if (res_e > EXT_W'(CAP)) begin
            hi = '1;
        end else begin
            hi = COORD_BITS'(res_e - EXT_W'(1));
        end
        hi_s = $signed({2'b00, hi});
        if (v < 0) begin
            r = '0;
        end else if (v > hi_s) begin
            r = hi;
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/mpct_pkt_asm.sv]
// ----------------------------------------------------------------------------
// mpct_pkt_asm
// Groups mouse bytes into three-byte packets and forms the signed deltas.
// ----------------------------------------------------------------------------
`default_nettype none

module mpct_pkt_asm (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic [mpct_pkg::BYTE_W-1:0]   i_byte,
    output mpct_pkg::t_pkt                     o_pkt
);

    logic [1:0]                  r_phase, n_phase;
    logic [mpct_pkg::BYTE_W-1:0] r_hdr;
    logic [mpct_pkg::BYTE_W-1:0] r_xbyte;

    always_comb begin
        n_phase        = mpct_pkg::PH_HEADER;
        o_pkt.done     = 1'b0;
        o_pkt.dx       = $signed({r_hdr[mpct_pkg::HDR_XSIGN], r_xbyte});
        o_pkt.dy       = $signed({r_hdr[mpct_pkg::HDR_YSIGN], i_byte});
        o_pkt.left     = r_hdr[mpct_pkg::HDR_LEFT];
        o_pkt.middle   = r_hdr[mpct_pkg::HDR_MIDDLE];
        o_pkt.right    = r_hdr[mpct_pkg::HDR_RIGHT];
        unique case (r_phase)
            mpct_pkg::PH_XBYTE: begin
                n_phase = mpct_pkg::PH_YBYTE;
            end
            mpct_pkg::PH_YBYTE: begin
                n_phase    = mpct_pkg::PH_HEADER;
                o_pkt.done = 1'b1;
            end
            default: begin
                // drop headers without the sync bit
                n_phase = i_byte[mpct_pkg::HDR_SYNC] ? mpct_pkg::PH_XBYTE
                                                     : mpct_pkg::PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mpct_pkg::PH_HEADER;
        end else if (i_adv) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (r_phase != mpct_pkg::PH_XBYTE && r_phase != mpct_pkg::PH_YBYTE
                && i_byte[mpct_pkg::HDR_SYNC]) begin
                r_hdr <= i_byte;
            end
            if (r_phase == mpct_pkg::PH_XBYTE) begin
                r_xbyte <= i_byte;
            end
        end
    end

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("byte phase reached unused code");

    a_hdr_synced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == mpct_pkg::PH_XBYTE) |-> r_hdr[mpct_pkg::HDR_SYNC])
        else $error("header held without sync bit");

    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_pkt.done) |=> (r_phase == mpct_pkg::PH_HEADER))
        else $error("phase did not return to header after packet");

endmodule

`default_nettype wire

[rtl/core/mpct_cursor.sv]
// ----------------------------------------------------------------------------
// mpct_cursor
// Holds screen size and cursor position; applies deltas and clamps.
// ----------------------------------------------------------------------------
`default_nettype none

module mpct_cursor (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_addr,
    input  wire logic [mpct_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                              i_adv,
    input  wire mpct_pkg::t_pkt                    i_pkt,
    output logic      [mpct_pkg::COORD_BITS-1:0]   o_next_x,
    output logic      [mpct_pkg::COORD_BITS-1:0]   o_next_y
);

    logic [mpct_pkg::CFG_W-1:0]        r_width;
    logic [mpct_pkg::CFG_W-1:0]        r_height;
    logic [mpct_pkg::COORD_BITS-1:0]   r_pos_x;
    logic [mpct_pkg::COORD_BITS-1:0]   r_pos_y;
    logic signed [mpct_pkg::SUM_W-1:0] w_sum_x;
    logic signed [mpct_pkg::SUM_W-1:0] w_sum_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= mpct_pkg::CFG_W'(640);
            r_height <= mpct_pkg::CFG_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                mpct_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                mpct_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // screen Y grows downward, so dy is subtracted
    always_comb begin
        w_sum_x  = $signed({2'b00, r_pos_x}) + mpct_pkg::SUM_W'(i_pkt.dx);
        w_sum_y  = $signed({2'b00, r_pos_y}) - mpct_pkg::SUM_W'(i_pkt.dy);
        o_next_x = mpct_pkg::clamp_axis(w_sum_x, r_width);
        o_next_y = mpct_pkg::clamp_axis(w_sum_y, r_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else if (i_adv && i_pkt.done) begin
            r_pos_x <= o_next_x;
            r_pos_y <= o_next_y;
        end
    end

    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_adv && i_pkt.done) |=> ($stable(r_pos_x) && $stable(r_pos_y)))
        else $error("cursor moved without a packet");

    a_pos_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_pkt.done) |=> (r_pos_x == $past(o_next_x)))
        else $error("cursor X not loaded on packet");

    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_we |=> ($stable(r_width) && $stable(r_height)))
        else $error("screen size changed without a write");

endmodule

`default_nettype wire

[rtl/core/ps2_mouse_packet_cursor_tracker_core.sv]
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_core
// PS/2 mouse packet decoder with clamped cursor tracking.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tdata[7:0] mouse byte
//  m_axis    out  tdata: cursor_x, cursor_y, left, middle, right
//  cfg       in   we / addr / data[12:0]; 0 = width, 1 = height
//
//  One byte per cycle unless a stalled result blocks the input stage (see below).
//  Path: input word register, then delta add and clamp into the result register.
//  Header and X bytes give no result; the Y byte gives one.
//  Synchronous reset: 640x480, cursor at 0,0, expecting a header byte.
//  A stalled result blocks the input stage only when that stage holds a Y byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_cursor_tracker_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [mpct_pkg::BYTE_W-1:0]         i_s_tdata,   // data_byte
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // cursor_x, cursor_y, left_button, middle_button, right_button, zero pad
    output logic      [mpct_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_addr,
    input  wire logic [mpct_pkg::CFG_W-1:0]          i_cfg_data
);

    logic                              r_in_valid;
    logic [mpct_pkg::BYTE_W-1:0]       r_in_byte;
    logic                              r_out_valid;
    logic [mpct_pkg::OUT_BITS-1:0]     r_out_word;
    logic                              w_adv;
    mpct_pkg::t_pkt                    w_pkt;
    logic [mpct_pkg::COORD_BITS-1:0]   w_next_x;
    logic [mpct_pkg::COORD_BITS-1:0]   w_next_y;

    // stage moves unless it holds a finished packet and the result is stuck
    assign w_adv      = r_in_valid && !(w_pkt.done && r_out_valid && !i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = mpct_pkg::OUT_TDATA_W'(r_out_word);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    mpct_pkt_asm u_asm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_byte  (r_in_byte),
        .o_pkt   (w_pkt)
    );

    mpct_cursor u_cursor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_adv      (w_adv),
        .i_pkt      (w_pkt),
        .o_next_x   (w_next_x),
        .o_next_y   (w_next_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_pkt.done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_pkt.done) begin
            r_out_word <= {w_pkt.right, w_pkt.middle, w_pkt.left, w_next_y, w_next_x};
        end
    end

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input word lost while stage stalled");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_pkt.done) |=> r_out_valid)
        else $error("finished packet gave no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !(w_adv && w_pkt.done))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

[tb/sv/mpct_cursor_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpct_cursor_checker
// Watches the byte, cursor and register channels of the cursor tracker,
// predicts each cursor word from the accepted mouse bytes and compares it
// field by field with the word the block hands out.
// ----------------------------------------------------------------------------

module mpct_cursor_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    input  logic [mpct_pkg::BYTE_W-1:0]        i_s_tdata,   // data_byte
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    // cursor_x, cursor_y, left_button, middle_button, right_button, zero pad
    input  logic [mpct_pkg::OUT_TDATA_W-1:0]   i_m_tdata,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_addr,
    input  logic [mpct_pkg::CFG_W-1:0]         i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import mpct_pkg::*;

    localparam int SIGN_WEIGHT = 256;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  left;
        logic                  middle;
        logic                  right;
    } t_cursor_word;

    logic [1:0]       byte_ph;
    logic [7:0]       hdr_q;
    logic [7:0]       xmove_q;
    int               cur_x;
    int               cur_y;
    logic [CFG_W-1:0] res_w;
    logic [CFG_W-1:0] res_h;
    int               fails;
    t_cursor_word     cursor_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fails        = 0;
    end

    // highest legal coordinate for a given resolution
    function automatic int axis_top(input logic [CFG_W-1:0] res);
        if (res == 0) return 0;
        if (res > CAP) return CAP - 1;
        return int'(res) - 1;
    endfunction

    function automatic int clamp_to(input int v, input logic [CFG_W-1:0] res);
        int top;
        top = axis_top(res);
        if (v < 0) return 0;
        if (v > top) return top;
        return v;
    endfunction

    task automatic track_mouse_byte(input logic [7:0] b);
        int           dx;
        int           dy;
        t_cursor_word w;
        case (byte_ph)
            PH_XBYTE: begin
                xmove_q = b;
                byte_ph = PH_YBYTE;
            end
            PH_YBYTE: begin
                // 9-bit deltas: sign from header, a set sign with zero byte is -256
                dx = int'(xmove_q);
                if (hdr_q[HDR_XSIGN]) dx -= SIGN_WEIGHT;
                dy = int'(b);
                if (hdr_q[HDR_YSIGN]) dy -= SIGN_WEIGHT;
                cur_x = clamp_to(cur_x + dx, res_w);
                cur_y = clamp_to(cur_y - dy, res_h);
                w.x      = cur_x[COORD_BITS-1:0];
                w.y      = cur_y[COORD_BITS-1:0];
                w.left   = hdr_q[HDR_LEFT];
                w.middle = hdr_q[HDR_MIDDLE];
                w.right  = hdr_q[HDR_RIGHT];
                cursor_q.push_back(w);
                byte_ph = PH_HEADER;
            end
            default: begin
                if (b[HDR_SYNC]) begin
                    hdr_q   = b;
                    byte_ph = PH_XBYTE;
                end else begin
                    byte_ph = PH_HEADER;
                end
            end
        endcase
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_cursor_word want;
        if (!i_rst_n) begin
            byte_ph = PH_HEADER;
            hdr_q   = '0;
            xmove_q = '0;
            cur_x   = 0;
            cur_y   = 0;
            res_w   = CFG_W'(640);
            res_h   = CFG_W'(480);
            cursor_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_WIDTH) begin
                    res_w = i_cfg_data;
                end else begin
                    res_h = i_cfg_data;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (cursor_q.size() == 0) begin
                    $display("%0t: unexpected cursor word, expected none, actual %h",
                             $time, i_m_tdata);
                    fails++;
                end else begin
                    want = cursor_q.pop_front();
                    check_field("cursor_x", int'(want.x),
                                int'(i_m_tdata[COORD_BITS-1:0]));
                    check_field("cursor_y", int'(want.y),
                                int'(i_m_tdata[2*COORD_BITS-1:COORD_BITS]));
                    check_field("left_button", int'(want.left),
                                int'(i_m_tdata[2*COORD_BITS]));
                    check_field("middle_button", int'(want.middle),
                                int'(i_m_tdata[2*COORD_BITS+1]));
                    check_field("right_button", int'(want.right),
                                int'(i_m_tdata[2*COORD_BITS+2]));
                    check_field("pad", 0, int'(i_m_tdata[OUT_TDATA_W-1:OUT_BITS]));
                end
            end
            if (i_s_tvalid && i_s_tready) track_mouse_byte(i_s_tdata);
        end
        o_pending    <= cursor_q.size();
        o_fail_count <= fails;
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives mouse bytes and screen sizes into the cursor tracker with random
// gaps and output stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module tb_top;
    import mpct_pkg::*;

    localparam int PACKETS_PER_PHASE = 18;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we   = 1'b0;
    logic                   cfg_addr = CFG_WIDTH;
    logic [CFG_W-1:0]       cfg_data = '0;
    int                     fails;
    int                     pending;

    bit quiet     = 1'b0;   // no gaps or stalls at all
    bit long_hold = 1'b0;   // sink holds off long enough to back up the input

    // bad headers, sign-set zero bytes, overflow bits, both clamp edges
    logic [7:0] intro_bytes [0:22] = '{
        8'h00, 8'hF7,
        8'h09, 8'hFF, 8'h00,
        8'h2E, 8'h10, 8'h00,
        8'hD8, 8'h00, 8'hFF,
        8'hFF, 8'h80, 8'h01,
        8'h0B, 8'hFF, 8'h80,
        8'h28, 8'hFF, 8'h00,
        8'h28, 8'hFF, 8'h00
    };

    ps2_mouse_packet_cursor_tracker_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data)
    );

    mpct_cursor_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // drift pushes right and down so the far clamp edges get reached
    task automatic send_packet(input bit drift);
        logic [7:0] hdr;
        logic [7:0] xb;
        logic [7:0] yb;
        hdr = 8'($urandom);
        hdr[HDR_SYNC] = 1'b1;
        if (drift) begin
            hdr[HDR_XSIGN] = 1'b0;
            hdr[HDR_YSIGN] = 1'b1;
            xb = 8'($urandom_range(192, 255));
            yb = 8'($urandom_range(0, 63));
        end else begin
            xb = 8'($urandom);
            yb = 8'($urandom);
        end
        // stray byte: dropped, or it knocks the packet out of alignment
        if ($urandom_range(0, 7) == 0) send_byte(8'($urandom));
        send_byte(hdr);
        send_byte(xb);
        send_byte(yb);
    endtask

    // header and X words leave no result, so keep waiting after nothing is pending
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_screen(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_addr <= CFG_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input bit drift);
        settle();
        load_screen(w, h);
        repeat (PACKETS_PER_PHASE) send_packet(drift);
    endtask

    initial begin : sink
        int hold;
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                for (hold = 0; hold < 60; hold++) @(posedge clk);
                long_hold = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int i;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 23; i++) send_byte(intro_bytes[i]);

        settle();
        load_screen(CFG_W'(1), CFG_W'(1));
        long_hold = 1'b1;
        repeat (PACKETS_PER_PHASE) send_packet(1'b0);

        run_phase(CFG_W'(4096), CFG_W'(4096), 1'b1);
        run_phase(CFG_W'(0), CFG_W'(8191), 1'b1);
        run_phase(CFG_W'(8191), CFG_W'(0), 1'b1);
        // lowered size: stored position gets pulled in at the next packet
        run_phase(CFG_W'(2000), CFG_W'(100), 1'b0);
        run_phase(CFG_W'($urandom_range(1, 4096)), CFG_W'($urandom_range(1, 4096)),
                  1'($urandom_range(0, 1)));
        quiet = 1'b1;
        run_phase(CFG_W'(640), CFG_W'(480), 1'b0);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fails == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
